[design/lhbp_pkg.sv]
// ----------------------------------------------------------------------------
// lhbp_pkg
// Shared types and fixed constants of the local history branch predictor.
// ----------------------------------------------------------------------------
package lhbp_pkg;

    // fixed field widths
    localparam int ADDR_BITS  = 32;
    localparam int ADDR_SHIFT = 2;
    localparam int TOTAL_BITS = 32;
    localparam int CFG_BITS   = 4;

    // counter width after reset
    localparam logic [CFG_BITS-1:0] CFG_RESET = 4'd2;

    // one input item
    typedef struct packed {
        logic [ADDR_BITS-1:0] branch_address;
        logic                 taken;
    } t_bp_in;

    // one result item
    typedef struct packed {
        logic                  predicted_taken;
        logic                  correct;
        logic [TOTAL_BITS-1:0] hit_total;
        logic [TOTAL_BITS-1:0] miss_total;
    } t_bp_out;

endpackage

[design/local_history_branch_predictor_unit.sv]
// ----------------------------------------------------------------------------
// local_history_branch_predictor_unit
// Two-level local branch predictor with a history table and a pattern table
// of saturating counters, updated with each resolved branch.
// ----------------------------------------------------------------------------
// After reset the unit clears both tables, one entry per cycle through as
// many entries as the larger table has (1024 by default), and takes no item
// until that is done; counter width writes are taken at any time. Each item
// then runs through two dependent reads of single-port-read RAMs: history
// index, history read, pattern index, pattern read, and write-back of both
// tables with the result. Each index step waits until its reduction unit is
// done, which takes longer for a table depth that is not a power of two. A
// finished result waits in an output register, and the next item is taken
// meanwhile; that next item holds in its last step until the waiting result
// is taken.
// ----------------------------------------------------------------------------
module local_history_branch_predictor_unit #(
    parameter int HISTORY_ENTRIES  = 128,
    parameter int PATTERN_ENTRIES  = 1024,
    parameter int HISTORY_BITS     = 10,
    parameter int MAX_COUNTER_BITS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [lhbp_pkg::CFG_BITS-1:0]     i_cfg_wdata,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  lhbp_pkg::t_bp_in                  i_in_data,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output lhbp_pkg::t_bp_out                 o_out_data
);

    localparam int HAW       = $clog2(HISTORY_ENTRIES);
    localparam int PAW       = $clog2(PATTERN_ENTRIES);
    localparam int CLR_DEPTH = (HISTORY_ENTRIES > PATTERN_ENTRIES) ?
                               HISTORY_ENTRIES : PATTERN_ENTRIES;
    localparam int CLR_W     = $clog2(CLR_DEPTH);
    localparam int IDX_BITS  = lhbp_pkg::ADDR_BITS - lhbp_pkg::ADDR_SHIFT;
    localparam int CB        = MAX_COUNTER_BITS;
    localparam int TB        = lhbp_pkg::TOTAL_BITS;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_HIDX = 5'b00010,
        S_HRD  = 5'b00100,
        S_PIDX = 5'b01000,
        S_PRD  = 5'b10000
    } t_state;

    t_state                       r_state, n_state;
    logic [lhbp_pkg::CFG_BITS-1:0] r_cfg;
    logic                         r_clearing;
    logic [CLR_W-1:0]             r_clr_idx;
    logic                         r_taken;
    logic [HISTORY_BITS-1:0]      r_hist;
    logic [TB-1:0]                r_hit, r_miss;
    logic                         r_out_valid;
    lhbp_pkg::t_bp_out            r_out;

    logic                         w_accept, w_finish;
    logic                         w_hmod_done, w_pmod_done;
    logic [HAW-1:0]               w_hidx;
    logic [PAW-1:0]               w_pidx;
    logic [HISTORY_BITS-1:0]      w_hist_rd;
    logic [CB-1:0]                w_cnt_rd;
    logic                         w_h_we, w_p_we;
    logic [HAW-1:0]               w_h_waddr;
    logic [PAW-1:0]               w_p_waddr;
    logic [HISTORY_BITS-1:0]      w_h_wdata;
    logic [CB-1:0]                w_p_wdata;
    logic [4:0]                   w_width;
    logic [CB-1:0]                w_cmax, w_half, w_cl, w_cnt_nx;
    logic                         w_pred, w_ok;

    // configuration register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= lhbp_pkg::CFG_RESET;
        end else if (i_cfg_we) begin
            r_cfg <= i_cfg_wdata;
        end
    end

    // clearing sweep after reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clearing <= 1'b1;
            r_clr_idx  <= '0;
        end else if (r_clearing) begin
            r_clr_idx <= r_clr_idx + 1'b1;
            if (r_clr_idx == CLR_W'(CLR_DEPTH - 1)) begin
                r_clearing <= 1'b0;
            end
        end
    end

    assign o_in_ready = (r_state == S_IDLE) && !r_clearing;
    assign w_accept   = i_in_valid && o_in_ready;
    assign w_finish   = (r_state == S_PRD) && (!r_out_valid || i_out_ready);

    // index reduction units
    lhbp_mod #(
        .WIDTH   (IDX_BITS),
        .MODULUS (HISTORY_ENTRIES)
    ) u_hmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (w_accept),
        .i_value  (i_in_data.branch_address[lhbp_pkg::ADDR_BITS-1:lhbp_pkg::ADDR_SHIFT]),
        .o_done   (w_hmod_done),
        .o_result (w_hidx)
    );

    lhbp_mod #(
        .WIDTH   (HISTORY_BITS),
        .MODULUS (PATTERN_ENTRIES)
    ) u_pmod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (r_state == S_HRD),
        .i_value  (w_hist_rd),
        .o_done   (w_pmod_done),
        .o_result (w_pidx)
    );

    // item sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: if (w_accept)    n_state = S_HIDX;
            S_HIDX: if (w_hmod_done) n_state = S_HRD;
            S_HRD:                   n_state = S_PIDX;
            S_PIDX: if (w_pmod_done) n_state = S_PRD;
            S_PRD:  if (w_finish)    n_state = S_IDLE;
            default:                 n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // item payload latches
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taken <= i_in_data.taken;
        end
        if (r_state == S_HRD) begin
            r_hist <= w_hist_rd;
        end
    end

    // counter width, limit and half point
    always_comb begin
        if (r_cfg == '0) begin
            w_width = 5'd1;
        end else if (5'(r_cfg) > 5'(CB)) begin
            w_width = 5'(CB);
        end else begin
            w_width = 5'(r_cfg);
        end
        for (int i = 0; i < CB; i++) begin
            w_cmax[i] = (5'(i) < w_width);
            w_half[i] = (5'(i) == (w_width - 5'd1));
        end
    end

    // clamp, predict and step the counter
    always_comb begin
        w_cl     = (w_cnt_rd > w_cmax) ? w_cmax : w_cnt_rd;
        w_pred   = |(w_cl & w_half);
        w_ok     = (w_pred == r_taken);
        w_cnt_nx = w_cl;
        if (r_taken) begin
            if (w_cl < w_cmax) begin
                w_cnt_nx = w_cl + 1'b1;
            end
        end else if (w_cl != '0) begin
            w_cnt_nx = w_cl - 1'b1;
        end
    end

    // table write ports, sweep or write-back
    always_comb begin
        if (r_clearing) begin
            w_h_we    = ({1'b0, r_clr_idx} < (CLR_W + 1)'(HISTORY_ENTRIES));
            w_p_we    = ({1'b0, r_clr_idx} < (CLR_W + 1)'(PATTERN_ENTRIES));
            w_h_waddr = r_clr_idx[HAW-1:0];
            w_p_waddr = r_clr_idx[PAW-1:0];
            w_h_wdata = '0;
            w_p_wdata = '0;
        end else begin
            w_h_we    = w_finish;
            w_p_we    = w_finish;
            w_h_waddr = w_hidx;
            w_p_waddr = w_pidx;
            w_h_wdata = HISTORY_BITS'({r_hist, r_taken});
            w_p_wdata = w_cnt_nx;
        end
    end

    // local history table
    lhbp_ram #(
        .WIDTH (HISTORY_BITS),
        .DEPTH (HISTORY_ENTRIES)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (w_h_waddr),
        .i_wdata (w_h_wdata),
        .i_re    ((r_state == S_HIDX) && w_hmod_done),
        .i_raddr (w_hidx),
        .o_rdata (w_hist_rd)
    );

    // pattern counter table
    lhbp_ram #(
        .WIDTH (CB),
        .DEPTH (PATTERN_ENTRIES)
    ) u_pat_ram (
        .i_clk   (i_clk),
        .i_we    (w_p_we),
        .i_waddr (w_p_waddr),
        .i_wdata (w_p_wdata),
        .i_re    ((r_state == S_PIDX) && w_pmod_done),
        .i_raddr (w_pidx),
        .o_rdata (w_cnt_rd)
    );

    // saturating hit and miss totals
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hit  <= '0;
            r_miss <= '0;
        end else if (w_finish) begin
            if (w_ok && (r_hit != '1)) begin
                r_hit <= r_hit + 1'b1;
            end
            if (!w_ok && (r_miss != '1)) begin
                r_miss <= r_miss + 1'b1;
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_finish) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_finish) begin
            r_out.predicted_taken <= w_pred;
            r_out.correct         <= w_ok;
            r_out.hit_total       <= (w_ok && (r_hit != '1)) ? r_hit + 1'b1 : r_hit;
            r_out.miss_total      <= (!w_ok && (r_miss != '1)) ? r_miss + 1'b1 : r_miss;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

[design/lhbp_ram.sv]
// ----------------------------------------------------------------------------
// lhbp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module lhbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read, held until the next read
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[design/lhbp_mod.sv]
// ----------------------------------------------------------------------------
// lhbp_mod
// Remainder of a value by a constant table depth: a mask for a power of two,
// otherwise a conditional subtract or a reciprocal multiplication, with the
// start passed on to done through r_stage.
// ----------------------------------------------------------------------------
module lhbp_mod #(
    parameter int WIDTH   = 30,
    parameter int MODULUS = 128
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [WIDTH-1:0]           i_value,
    output logic                       o_done,
    output logic [$clog2(MODULUS)-1:0] o_result
);

    localparam int RW     = $clog2(MODULUS);
    localparam int EW     = (WIDTH > RW) ? WIDTH : RW;
    localparam bit IS_POW = ((1 << RW) == MODULUS);

    logic          r_done;
    logic [RW-1:0] r_rem;

    generate
        if (IS_POW) begin : g_mask
            logic [EW-1:0] w_ext;

            assign w_ext = EW'(i_value);

            // low bits, ready in the cycle after start
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_done <= 1'b0;
                end else begin
                    r_done <= i_start;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_rem <= w_ext[RW-1:0];
                end
            end
        end else if (WIDTH <= RW) begin : g_sub
            logic          r_stage;
            logic [RW-1:0] r_val;

            // value stays below twice the modulus; done follows start through r_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= 1'b0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= i_start;
                    r_done  <= r_stage;
                end
            end

            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val <= RW'(i_value);
                end
            end

            // one conditional subtract
            always_ff @(posedge i_clk) begin
                if (r_stage) begin
                    if (r_val >= RW'(MODULUS)) begin
                        r_rem <= r_val - RW'(MODULUS);
                    end else begin
                        r_rem <= r_val;
                    end
                end
            end
        end else begin : g_recip
            localparam int     MW    = WIDTH + 1;
            localparam int     PW    = WIDTH + MW;
            localparam int     SH    = WIDTH + RW;
            localparam longint RECIP = ((longint'(1) << SH) + longint'(MODULUS) - 1)
                                       / longint'(MODULUS);

            logic             r_stage;
            logic [WIDTH-1:0] r_val;
            logic [PW-1:0]    r_prod;
            logic [WIDTH-1:0] w_quot;
            logic [WIDTH-1:0] w_diff;

            // done follows start through r_stage
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_stage <= 1'b0;
                    r_done  <= 1'b0;
                end else begin
                    r_stage <= i_start;
                    r_done  <= r_stage;
                end
            end

            // first step: value times the scaled reciprocal
            always_ff @(posedge i_clk) begin
                if (i_start) begin
                    r_val  <= i_value;
                    r_prod <= PW'(i_value) * PW'(RECIP);
                end
            end

            // second step: quotient from the high product bits, value minus
            // quotient times modulus
            always_comb begin
                w_quot = WIDTH'(r_prod[PW-1:SH]);
                w_diff = r_val - w_quot * WIDTH'(MODULUS);
            end

            always_ff @(posedge i_clk) begin
                if (r_stage) begin
                    r_rem <= w_diff[RW-1:0];
                end
            end
        end
    endgenerate

    assign o_done   = r_done;
    assign o_result = r_rem;

endmodule

[sim/local_history_branch_predictor_unit_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// local_history_branch_predictor_unit_tb
// Streams resolved branches through the predictor and checks every result
// item against an in-bench two-level predictor with its own tables. The
// counter width is changed between phases while the unit is idle, and both
// handshake sides are throttled at different rates.
// ----------------------------------------------------------------------------
module local_history_branch_predictor_unit_tb;

    localparam int HIST_ENTRIES = 128;
    localparam int PAT_ENTRIES  = 1024;
    localparam int HIST_BITS    = 10;
    localparam int MAX_CTR_BITS = 8;
    localparam int PHASE_COUNT  = 10;
    localparam int PHASE_ITEMS  = 158;

    typedef enum logic [1:0] {ENTRY_ITEM, ENTRY_CONFIG, ENTRY_DRAIN} t_entry_kind;
    typedef enum logic [1:0] {RUN_TAKEN, RUN_NOT_TAKEN, RUN_LOOP, RUN_BIASED} t_run_kind;
    typedef enum logic [1:0] {PACE_SLOW_SEND, PACE_SLOW_RECV, PACE_FULL} t_pace;

    typedef struct {
        t_entry_kind                   kind;
        lhbp_pkg::t_bp_in              item;
        logic [lhbp_pkg::CFG_BITS-1:0] width;
    } t_send_entry;

    logic                          i_clk       = 1'b0;
    logic                          i_rst_n     = 1'b0;
    logic                          i_cfg_we    = 1'b0;
    logic [lhbp_pkg::CFG_BITS-1:0] i_cfg_wdata = lhbp_pkg::CFG_RESET;
    logic                          i_in_valid  = 1'b0;
    logic                          o_in_ready;
    lhbp_pkg::t_bp_in              i_in_data   = '0;
    logic                          o_out_valid;
    logic                          i_out_ready = 1'b0;
    lhbp_pkg::t_bp_out             o_out_data;

    // predictor state kept by the bench
    bit   [HIST_BITS-1:0]            hist_tab [HIST_ENTRIES];
    bit   [MAX_CTR_BITS-1:0]         ctr_tab  [PAT_ENTRIES];
    logic [lhbp_pkg::TOTAL_BITS-1:0] hit_tally  = '0;
    logic [lhbp_pkg::TOTAL_BITS-1:0] miss_tally = '0;
    logic [lhbp_pkg::CFG_BITS-1:0]   ctr_width  = lhbp_pkg::CFG_RESET;

    t_send_entry       branch_stream[$];
    lhbp_pkg::t_bp_out expected_outcomes[$];
    bit                in_fire;
    int                items_accepted;
    int                results_seen;
    int                mismatches;
    int                settings_used = 1;
    int                hold_left;
    bit                hold_done;

    local_history_branch_predictor_unit #(
        .HISTORY_ENTRIES  (HIST_ENTRIES),
        .PATTERN_ENTRIES  (PAT_ENTRIES),
        .HISTORY_BITS     (HIST_BITS),
        .MAX_COUNTER_BITS (MAX_CTR_BITS)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    // predict one branch and update the bench tables
    function automatic lhbp_pkg::t_bp_out resolve_branch(input lhbp_pkg::t_bp_in br);
        lhbp_pkg::t_bp_out  res;
        int unsigned        n, cmax, half, ctr, hidx, pidx;
        bit [HIST_BITS-1:0] hist;
        n = ctr_width;
        if (n < 1)
            n = 1;
        if (n > MAX_CTR_BITS)
            n = MAX_CTR_BITS;
        cmax = (1 << n) - 1;
        half = 1 << (n - 1);
        hidx = (br.branch_address >> lhbp_pkg::ADDR_SHIFT) % HIST_ENTRIES;
        hist = hist_tab[hidx];
        pidx = hist % PAT_ENTRIES;
        ctr  = ctr_tab[pidx];
        // a counter left above range by a narrower width is clamped first
        if (ctr > cmax)
            ctr = cmax;
        res.predicted_taken = (ctr >= half);
        res.correct         = (res.predicted_taken == br.taken);
        if (br.taken) begin
            if (ctr < cmax)
                ctr++;
        end else if (ctr > 0) begin
            ctr--;
        end
        ctr_tab[pidx]  = MAX_CTR_BITS'(ctr);
        hist_tab[hidx] = {hist[HIST_BITS-2:0], br.taken};
        // totals stick at all ones
        if (res.correct) begin
            if (hit_tally != '1)
                hit_tally++;
        end else if (miss_tally != '1) begin
            miss_tally++;
        end
        res.hit_total  = hit_tally;
        res.miss_total = miss_tally;
        return res;
    endfunction

    // throttling follows how far the stream has got
    function automatic t_pace pace();
        if (items_accepted < 540)
            return PACE_SLOW_SEND;
        if (items_accepted < 1080)
            return PACE_SLOW_RECV;
        return PACE_FULL;
    endfunction

    task automatic push_item(input logic [lhbp_pkg::ADDR_BITS-1:0] addr, input logic tk);
        t_send_entry e;
        e.kind                = ENTRY_ITEM;
        e.item.branch_address = addr;
        e.item.taken          = tk;
        e.width               = '0;
        branch_stream.push_back(e);
    endtask

    task automatic push_control(input t_entry_kind kind,
                                input logic [lhbp_pkg::CFG_BITS-1:0] w);
        t_send_entry e;
        e.kind  = kind;
        e.item  = '0;
        e.width = w;
        branch_stream.push_back(e);
        if (kind == ENTRY_CONFIG)
            settings_used++;
    endtask

    // runs of one branch with a recognizable pattern, mixed with noise
    task automatic add_branch_runs(input int goal);
        logic [lhbp_pkg::ADDR_BITS-1:0] pool [8];
        t_run_kind                      kind;
        int                             made, len, period, bias, pick;
        logic                           tk;
        foreach (pool[k])
            pool[k] = $urandom;
        made = 0;
        while (made < goal) begin
            if ($urandom_range(99) < 20) begin
                push_item($urandom, 1'($urandom_range(1)));
                made++;
            end else begin
                pick   = $urandom_range(7);
                kind   = t_run_kind'($urandom_range(3));
                len    = $urandom_range(4, 20);
                period = $urandom_range(2, 8);
                bias   = $urandom_range(10, 90);
                for (int i = 0; i < len; i++) begin
                    case (kind)
                        RUN_TAKEN:     tk = 1'b1;
                        RUN_NOT_TAKEN: tk = 1'b0;
                        RUN_LOOP:      tk = ((i % period) != (period - 1));
                        default:       tk = ($urandom_range(99) < bias);
                    endcase
                    push_item(pool[pick], tk);
                    made++;
                end
            end
        end
    endtask

    // driver: one queue entry per falling edge at most
    always @(negedge i_clk) begin
        logic             next_valid;
        lhbp_pkg::t_bp_in next_data;
        logic             next_we;
        int               idle_pct;
        next_valid = i_in_valid;
        next_data  = i_in_data;
        next_we    = 1'b0;
        idle_pct   = (pace() == PACE_SLOW_SEND) ? 34 : (pace() == PACE_SLOW_RECV) ? 88 : 0;
        if (i_rst_n) begin
            if (i_in_valid && in_fire)
                next_valid = 1'b0;
            if (!next_valid && branch_stream.size() > 0) begin
                case (branch_stream[0].kind)
                    ENTRY_ITEM: begin
                        if ($urandom_range(99) >= idle_pct) begin
                            next_data  = branch_stream[0].item;
                            next_valid = 1'b1;
                            void'(branch_stream.pop_front());
                        end
                    end
                    default: begin
                        // config and pause entries wait for the unit to drain
                        if (expected_outcomes.size() == 0) begin
                            if (branch_stream[0].kind == ENTRY_CONFIG) begin
                                next_we = 1'b1;
                                i_cfg_wdata <= branch_stream[0].width;
                            end
                            void'(branch_stream.pop_front());
                        end
                    end
                endcase
            end
        end
        i_in_valid <= next_valid;
        i_in_data  <= next_data;
        i_cfg_we   <= next_we;
    end

    // receiver: random stalls plus one long hold-off under full pace
    always @(negedge i_clk) begin
        int idle_pct;
        idle_pct = (pace() == PACE_SLOW_SEND) ? 88 : (pace() == PACE_SLOW_RECV) ? 34 : 0;
        if (hold_left > 0) begin
            hold_left--;
            i_out_ready <= 1'b0;
        end else if (!hold_done && results_seen >= 1200) begin
            hold_done = 1'b1;
            hold_left = 400;
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= ($urandom_range(99) >= idle_pct);
        end
    end

    // monitor: config tracking, result checks, predictions for new items
    always @(posedge i_clk) begin
        lhbp_pkg::t_bp_out want;
        in_fire = i_in_valid && o_in_ready;
        if (i_rst_n) begin
            if (i_cfg_we)
                ctr_width = i_cfg_wdata;
            if (o_out_valid && i_out_ready) begin
                results_seen++;
                if (expected_outcomes.size() == 0) begin
                    $error("result item with no branch pending");
                    mismatches++;
                end else begin
                    want = expected_outcomes.pop_front();
                    if (o_out_data.predicted_taken !== want.predicted_taken) begin
                        $error("predicted_taken: expected %0d, got %0d",
                               want.predicted_taken, o_out_data.predicted_taken);
                        mismatches++;
                    end
                    if (o_out_data.correct !== want.correct) begin
                        $error("correct: expected %0d, got %0d",
                               want.correct, o_out_data.correct);
                        mismatches++;
                    end
                    if (o_out_data.hit_total !== want.hit_total) begin
                        $error("hit_total: expected %0d, got %0d",
                               want.hit_total, o_out_data.hit_total);
                        mismatches++;
                    end
                    if (o_out_data.miss_total !== want.miss_total) begin
                        $error("miss_total: expected %0d, got %0d",
                               want.miss_total, o_out_data.miss_total);
                        mismatches++;
                    end
                end
            end
            if (in_fire) begin
                expected_outcomes.push_back(resolve_branch(i_in_data));
                items_accepted++;
            end
        end
    end

    // stimulus, reset and end of run
    initial begin
        logic [lhbp_pkg::CFG_BITS-1:0] phase_widths [PHASE_COUNT];
        phase_widths = '{4'd8, 4'd1, 4'd15, 4'd0, 4'd4, 4'd2, 4'd3, 4'd8, 4'd7, 4'd5};

        // directed: address extremes, ignored low bits, aliasing upper bits
        push_item(32'h0000_0000, 1'b1);
        push_item(32'hFFFF_FFFF, 1'b0);
        push_item(32'hFFFF_FFFF, 1'b1);
        push_item(32'h5555_5555, 1'b1);
        push_item(32'hAAAA_AAAA, 1'b0);
        push_item(32'h0000_0003, 1'b1);
        push_item(32'h0000_0200, 1'b0);
        // one branch taken 12 times, then not taken 3 times: history fills with ones
        repeat (12)
            push_item(32'h0000_0100, 1'b1);
        repeat (3)
            push_item(32'h0000_0100, 1'b0);
        push_item(32'h0000_01FC, 1'b1);
        push_item(32'h8000_0000, 1'b0);

        // random phases, each under its own counter width
        for (int p = 0; p < PHASE_COUNT; p++) begin
            push_control(ENTRY_CONFIG, phase_widths[p]);
            add_branch_runs(PHASE_ITEMS / 2);
            if (p % 3 == 2)
                push_control(ENTRY_DRAIN, '0);
            add_branch_runs(PHASE_ITEMS - PHASE_ITEMS / 2);
        end

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (branch_stream.size() > 0 || i_in_valid)
            @(posedge i_clk);
        for (int c = 0; c < 5000 && expected_outcomes.size() > 0; c++)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (expected_outcomes.size() > 0) begin
            $error("%0d branch results never arrived", expected_outcomes.size());
            mismatches++;
        end

        $display("%0d branch items checked over %0d counter width settings",
                 items_accepted, settings_used);
        $display("final tallies: %0d hits, %0d misses", hit_tally, miss_tally);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

    // watchdog
    initial begin
        #4_000_000;
        $display("Verification failed");
        $finish;
    end

endmodule
